// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the frame parser rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the asynchronous reset is asserted
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/imurvc_pkg.sv =====
// shared types and constants for the imu rvc frame parser
// no dependencies; used by imurvc_parse and imu_rvc_frame_parser_top
package imurvc_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hAA;
	localparam int         BODY_LEN  = 17;
	localparam int         STORE_LEN = 15;
	localparam int         POS_W     = 5;
	localparam logic [POS_W-1:0] CHECK_POS = POS_W'(BODY_LEN - 1);

	// bits of tdata ahead of the two counters
	localparam int FRAME_DATA_W = 120;

	// decoded frame fields, counters travel separately
	typedef struct packed {
		logic        [7:0]  frame_index;
		logic signed [15:0] yaw_raw;
		logic signed [15:0] pitch_raw;
		logic signed [15:0] roll_raw;
		logic signed [15:0] accel_x_mg;
		logic signed [15:0] accel_y_mg;
		logic signed [15:0] accel_z_mg;
		logic        [7:0]  intent_code;
		logic        [7:0]  request_code;
		logic               checksum_ok;
	} frame_t;

	// status from the parser back to the stream control
	typedef struct packed {
		logic ends_frame;  // byte in the input register is a checksum byte
		logic frame_done;  // a frame completes at this edge
	} parse_status_t;

endpackage

// ===== rtl/core/imurvc_parse.sv =====
// header hunt, body collection, checksum and frame counters
// depends on imurvc_pkg
module imurvc_parse #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  rx_byte,
	output imurvc_pkg::parse_status_t   status,
	output imurvc_pkg::frame_t          frame,
	output logic [COUNT_WIDTH-1:0]      good_frames,
	output logic [COUNT_WIDTH-1:0]      bad_checksums
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_ONE  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	phase_t                              phase_q;
	logic [imurvc_pkg::POS_W-1:0]        pos_q;
	logic [7:0]                          sum_q;
	logic [7:0]                          store_q [imurvc_pkg::STORE_LEN];
	logic [COUNT_WIDTH-1:0]              good_q;
	logic [COUNT_WIDTH-1:0]              bad_q;
	logic                                ends_frame;
	logic                                sum_ok;

	// position CHECK_POS, the last of the body bytes, counts as the checksum byte
	assign ends_frame = (phase_q == PH_BODY) && (pos_q >= imurvc_pkg::CHECK_POS);
	assign sum_ok     = (rx_byte == sum_q);

	assign status.ends_frame = ends_frame;
	assign status.frame_done = step && ends_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			sum_q   <= '0;
			good_q  <= '0;
			bad_q   <= '0;
		end else if (step) begin
			unique case (phase_q)
				PH_ONE: begin
					if (rx_byte == imurvc_pkg::HDR_BYTE) begin
						phase_q <= PH_BODY;
						pos_q   <= '0;
						sum_q   <= '0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_BODY: begin
					if (!ends_frame) begin
						sum_q <= sum_q + rx_byte;
						pos_q <= pos_q + imurvc_pkg::POS_W'(1);
					end else begin
						if (sum_ok) good_q <= good_q + COUNT_WIDTH'(1);
						else        bad_q  <= bad_q + COUNT_WIDTH'(1);
						phase_q <= PH_HUNT;
						pos_q   <= '0;
						sum_q   <= '0;
					end
				end
				default: begin
					// hunting, also the unused phase code
					phase_q <= (rx_byte == imurvc_pkg::HDR_BYTE) ? PH_ONE : PH_HUNT;
				end
			endcase
		end
	end

	// body bytes shift in from the top, so entry 0 ends up holding frame byte 2
	always_ff @(posedge clk) begin
		if (step && (phase_q == PH_BODY) &&
		    (pos_q < imurvc_pkg::POS_W'(imurvc_pkg::STORE_LEN))) begin
			for (int i = 0; i < imurvc_pkg::STORE_LEN - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[imurvc_pkg::STORE_LEN-1] <= rx_byte;
		end
	end

	assign frame.frame_index    = store_q[0];
	assign frame.yaw_raw        = {store_q[2],  store_q[1]};
	assign frame.pitch_raw      = {store_q[4],  store_q[3]};
	assign frame.roll_raw       = {store_q[6],  store_q[5]};
	assign frame.accel_x_mg     = {store_q[8],  store_q[7]};
	assign frame.accel_y_mg     = {store_q[10], store_q[9]};
	assign frame.accel_z_mg     = {store_q[12], store_q[11]};
	assign frame.intent_code    = store_q[13];
	assign frame.request_code   = store_q[14];
	assign frame.checksum_ok    = sum_ok;

	// counts including the frame completing now
	assign good_frames   = sum_ok ? (good_q + COUNT_WIDTH'(1)) : good_q;
	assign bad_checksums = sum_ok ? bad_q : (bad_q + COUNT_WIDTH'(1));

endmodule

// ===== rtl/core/imurvc_out_reg.sv =====
// result register on the master stream side
// no dependencies; instantiated by imu_rvc_frame_parser_top
module imurvc_out_reg #(
	parameter int DATA_W = 184
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [DATA_W-1:0] load_data,
	input  logic              load_user,
	output logic              room,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,
	output logic              m_axis_tuser
);

	logic              valid_q;
	logic [DATA_W-1:0] data_q;
	logic              user_q;

	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
			user_q <= load_user;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

// ===== rtl/core/imu_rvc_frame_parser_top.sv =====
// top level of the imu rvc frame parser: input register, parser, result register
// depends on imurvc_pkg, imurvc_parse, imurvc_out_reg and assert_macros.svh
//
// Byte-serial parser for the rvc inertial-sensor frame. Each request on the
// slave stream carries one received byte. The parser hunts for two 0xAA header
// bytes, collects the 17 body bytes and checks the last against the mod-256 sum
// of the 16 before it. Every completed frame, good or bad, yields one request on
// the master stream with the raw decoded fields, a checksum-ok flag in tuser and
// the wrapping good-frame and bad-checksum counts, both including this frame.
// Throughput is one byte per clock. A byte is taken into the input register and
// processed from there; the result register loads at the edge where the checksum
// byte leaves the input register, so a result is valid once its checksum byte has
// passed the input register and the result register has room for it. The slave
// side stalls only when a checksum byte sits in the input register while the
// result register still holds an earlier frame that is not being taken; other
// bytes keep flowing while a result waits. Counters are COUNT_WIDTH bits and wrap.
module imu_rvc_frame_parser_top #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream, one received byte per request
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
	// master stream, one decoded frame per request
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// from bit 0: frame_index 8, yaw_raw 16, pitch_raw 16, roll_raw 16,
	// accel_x_mg 16, accel_y_mg 16, accel_z_mg 16, intent_code 8,
	// request_code 8, good_frames COUNT_WIDTH, bad_checksums COUNT_WIDTH, zero pad
	output logic [((imurvc_pkg::FRAME_DATA_W + 2*COUNT_WIDTH + 7) / 8) * 8 - 1:0]
	                            m_axis_tdata,
	output logic                m_axis_tuser    // [0] checksum_ok
);

`include "assert_macros.svh"

	localparam int PAYLOAD_W = imurvc_pkg::FRAME_DATA_W + 2*COUNT_WIDTH;
	localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

	// input register
	logic                      valid_s1;
	logic [7:0]                byte_s1;

	logic                      consume;
	logic                      out_room;
	imurvc_pkg::parse_status_t status;
	imurvc_pkg::frame_t        frame;
	logic [COUNT_WIDTH-1:0]    good_frames;
	logic [COUNT_WIDTH-1:0]    bad_checksums;
	logic [TDATA_W-1:0]        packed_data;

	// a byte leaves the input register unless it completes a frame with no room
	assign consume       = valid_s1 && (!status.ends_frame || out_room);
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	imurvc_parse #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (consume),
		.rx_byte       (byte_s1),
		.status        (status),
		.frame         (frame),
		.good_frames   (good_frames),
		.bad_checksums (bad_checksums)
	);

	// field packing, first field in the low bits, zero fill to whole bytes
	always_comb begin
		packed_data = '0;
		packed_data[imurvc_pkg::FRAME_DATA_W-1:0] = {
			frame.request_code,
			frame.intent_code,
			frame.accel_z_mg,
			frame.accel_y_mg,
			frame.accel_x_mg,
			frame.roll_raw,
			frame.pitch_raw,
			frame.yaw_raw,
			frame.frame_index
		};
		packed_data[imurvc_pkg::FRAME_DATA_W +: COUNT_WIDTH]               = good_frames;
		packed_data[imurvc_pkg::FRAME_DATA_W + COUNT_WIDTH +: COUNT_WIDTH] = bad_checksums;
	end

	imurvc_out_reg #(
		.DATA_W (TDATA_W)
	) u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (status.frame_done),
		.load_data     (packed_data),
		.load_user     (frame.checksum_ok),
		.room          (out_room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// a completed frame always shows up on the master side next cycle
	`ASSERT_CLKRST(a_done_to_out, clk, arst_n, status.frame_done |=> m_axis_tvalid, "frame lost")
	// a new frame never overwrites a pending result that is not being taken
	`ASSERT_CLKRST(a_no_overwrite, clk, arst_n, status.frame_done |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
	// a byte that cannot be processed stays in the input register unchanged
	`ASSERT_CLKRST(a_s1_hold, clk, arst_n, (valid_s1 && !consume) |=> (valid_s1 && $stable(byte_s1)), "input byte dropped")

endmodule

// ===== tb/tb_imu_rvc_frame_parser_top.sv =====
// self-checking testbench for imu_rvc_frame_parser_top: byte stream in, decoded frames out
// depends on imurvc_pkg and the parser rtl; a built-in frame predictor checks every result
module tb_imu_rvc_frame_parser_top;

	localparam int CW             = 32;
	localparam int TDATA_W        = ((imurvc_pkg::FRAME_DATA_W + 2*CW + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 8;

	typedef enum logic [1:0] {SEEK_HDR, HDR_SEEN, IN_BODY} hunt_state_t;

	typedef struct packed {
		imurvc_pkg::frame_t fr;
		logic [CW-1:0]      good;
		logic [CW-1:0]      bad;
	} frame_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	imu_rvc_frame_parser_top #(.COUNT_WIDTH(CW)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	logic [7:0]    byte_q [$];
	frame_report_t frame_q [$];
	int            mismatches = 0;
	int unsigned   cyc = 0;
	int unsigned   quiet = 0;

	// predictor state
	hunt_state_t   hunt = SEEK_HDR;
	logic [4:0]    body_pos = '0;
	logic [7:0]    body_sum = '0;
	logic [7:0]    body_bytes [imurvc_pkg::STORE_LEN];
	logic [CW-1:0] good_total = '0;
	logic [CW-1:0] bad_total = '0;

	task automatic parse_byte(input logic [7:0] b);
		frame_report_t r;
		case (hunt)
			HDR_SEEN: begin
				if (b == imurvc_pkg::HDR_BYTE) begin
					hunt = IN_BODY;
					body_pos = '0;
					body_sum = '0;
				end else
					hunt = SEEK_HDR;
			end
			IN_BODY: begin
				if (body_pos < imurvc_pkg::CHECK_POS) begin
					if (body_pos < imurvc_pkg::STORE_LEN)
						body_bytes[body_pos[3:0]] = b;
					body_sum = body_sum + b;
					body_pos = body_pos + 1'b1;
				end else begin
					r.fr.checksum_ok = (b == body_sum);
					if (r.fr.checksum_ok)
						good_total = good_total + 1'b1;
					else
						bad_total = bad_total + 1'b1;
					r.fr.frame_index    = body_bytes[0];
					r.fr.yaw_raw        = {body_bytes[2], body_bytes[1]};
					r.fr.pitch_raw      = {body_bytes[4], body_bytes[3]};
					r.fr.roll_raw       = {body_bytes[6], body_bytes[5]};
					r.fr.accel_x_mg     = {body_bytes[8], body_bytes[7]};
					r.fr.accel_y_mg     = {body_bytes[10], body_bytes[9]};
					r.fr.accel_z_mg     = {body_bytes[12], body_bytes[11]};
					r.fr.intent_code    = body_bytes[13];
					r.fr.request_code   = body_bytes[14];
					r.good = good_total;
					r.bad  = bad_total;
					frame_q.push_back(r);
					hunt = SEEK_HDR;
					body_pos = '0;
					body_sum = '0;
				end
			end
			default: hunt = (b == imurvc_pkg::HDR_BYTE) ? HDR_SEEN : SEEK_HDR;
		endcase
	endtask

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			4: return imurvc_pkg::HDR_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_frame(input logic [7:0] body [16], input bit bad_sum);
		logic [7:0] sum;
		sum = 8'h00;
		byte_q.push_back(imurvc_pkg::HDR_BYTE);
		byte_q.push_back(imurvc_pkg::HDR_BYTE);
		foreach (body[i]) begin
			byte_q.push_back(body[i]);
			sum = sum + body[i];
		end
		byte_q.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	task automatic push_random_frame(input bit bad_sum);
		logic [7:0] body [16];
		foreach (body[i])
			body[i] = body_byte();
		push_frame(body, bad_sum);
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
	                             input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// byte sender
	int unsigned send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				parse_byte(s_tdata);
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= byte_q.pop_front();
				send_gap <= (cyc[9:8] == 2'd0) ? 0 : idle_len();
			end else
				s_tvalid <= 1'b0;
		end
	end

	// frame receiver and checker
	frame_report_t oldest;
	int unsigned   rx_stall = 0;
	int unsigned   hold_left = 0;
	int unsigned   frames_seen = 0;
	int unsigned   next_hold = 5;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				frames_seen <= frames_seen + 1;
				if (frame_q.size() == 0) begin
					$display("%0t: unexpected frame, expected none, actual %h / %b",
					         $time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					oldest = frame_q.pop_front();
					compare_field("frame_index", oldest.fr.frame_index, m_tdata[7:0]);
					compare_field("yaw_raw", $unsigned(oldest.fr.yaw_raw), m_tdata[23:8]);
					compare_field("pitch_raw", $unsigned(oldest.fr.pitch_raw),
					              m_tdata[39:24]);
					compare_field("roll_raw", $unsigned(oldest.fr.roll_raw), m_tdata[55:40]);
					compare_field("accel_x_mg", $unsigned(oldest.fr.accel_x_mg),
					              m_tdata[71:56]);
					compare_field("accel_y_mg", $unsigned(oldest.fr.accel_y_mg),
					              m_tdata[87:72]);
					compare_field("accel_z_mg", $unsigned(oldest.fr.accel_z_mg),
					              m_tdata[103:88]);
					compare_field("intent_code", oldest.fr.intent_code, m_tdata[111:104]);
					compare_field("request_code", oldest.fr.request_code,
					              m_tdata[119:112]);
					compare_field("checksum_ok", oldest.fr.checksum_ok, m_tuser);
					compare_field("good_frames", oldest.good,
					              m_tdata[imurvc_pkg::FRAME_DATA_W +: CW]);
					compare_field("bad_checksums", oldest.bad,
					              m_tdata[imurvc_pkg::FRAME_DATA_W + CW +: CW]);
				end
			end
			// a long hold now and then lets the input side back up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (frames_seen >= next_hold) begin
				hold_left <= LONG_HOLD;
				next_hold <= next_hold + 40;
				m_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_stall <= (cyc[10:9] == 2'd0) ? 0 : idle_len();
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else if (quiet == WATCHDOG_LIMIT) begin
				$display("imu_rvc_frame_parser_top verification failed");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned n;
		// noise, then a header broken by a non-header byte
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		byte_q.push_back(imurvc_pkg::HDR_BYTE);
		byte_q.push_back(8'h55);
		// good frame with extreme values and header bytes inside the body
		push_frame('{8'hAA, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00,
		             8'hAA, 8'hAA, 8'h01, 8'h80, 8'h00, 8'hFF, 8'hAA}, 1'b0);
		// rejected frame still yields its decoded fields
		push_frame('{8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h34, 8'h12,
		             8'hFE, 8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'h55}, 1'b1);

		while (byte_q.size() < 1250) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				push_random_frame(1'b0);
			else if (pick < 82)
				push_random_frame(1'b1);
			else if (pick < 90) begin
				n = $urandom_range(1, 4);
				repeat (n) byte_q.push_back(8'($urandom));
			end else if (pick < 96) begin
				byte_q.push_back(imurvc_pkg::HDR_BYTE);
				byte_q.push_back(8'($urandom_range(0, 8'hA9)));
			end else begin
				// cut-off frame: following bytes are taken as its body
				byte_q.push_back(imurvc_pkg::HDR_BYTE);
				byte_q.push_back(imurvc_pkg::HDR_BYTE);
				n = $urandom_range(1, 10);
				repeat (n) byte_q.push_back(body_byte());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || s_tvalid || frame_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("imu_rvc_frame_parser_top verification clean");
		else
			$display("imu_rvc_frame_parser_top verification failed");
		$finish;
	end

endmodule
